/* rtl/core/ip_address_text_validator_top_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the IP address text validator
// Shorthand for clocked assertions with a synchronous active-low reset.
// ----------------------------------------------------------------------------
`ifndef IP_ADDRESS_TEXT_VALIDATOR_TOP_MACROS_SVH
`define IP_ADDRESS_TEXT_VALIDATOR_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IPVAL_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ipval assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define IPVAL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ipval assertion failed");

`endif

/* rtl/core/ipval_pkg.sv */
// ----------------------------------------------------------------------------
// IP address text validator package
// Character classes, the token passed from front to back, and verdict codes.
// ----------------------------------------------------------------------------
package ipval_pkg;

    // Classes of an input character as seen by the checking logic.
    typedef enum logic [2:0] {
        CLS_DOT   = 3'd0,
        CLS_COLON = 3'd1,
        CLS_DIGIT = 3'd2,
        CLS_HEX   = 3'd3,
        CLS_OTHER = 3'd4
    } t_char_class;

    typedef enum logic [1:0] {
        VERDICT_NONE = 2'd0,
        VERDICT_IPV4 = 2'd1,
        VERDICT_IPV6 = 2'd2
    } t_verdict;

    // One classified character.
    typedef struct packed {
        t_char_class cls;
        logic [3:0]  digit;
        logic        last;
    } t_token;

    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_COLON = 8'h3A;

    localparam logic [9:0] V4_MAX_VALUE = 10'd255;
    localparam logic [2:0] V4_DOTS      = 3'd3;
    localparam logic [3:0] V6_COLONS    = 4'd7;
    localparam logic [2:0] V4_MAX_LEN   = 3'd3;
    localparam logic [2:0] V6_MAX_LEN   = 3'd4;

endpackage

/* rtl/core/ip_address_text_validator_top.sv */
// ----------------------------------------------------------------------------
// IP address text validator
// Checks address text, one character per item, and reports IPv4, IPv6 or neither.
// ----------------------------------------------------------------------------
// The block takes one character item per cycle while full is low and gives
// one verdict item for each string, after the character marked as last. A
// character item is classified as it is accepted and written to a short token
// queue; the checking logic takes one token per cycle from that queue unless a
// last character is held back, so the sustained rate is one character per
// clock, set by the per-token update of the group and delimiter counters. A
// character is registered in the token queue before the checking logic sees
// it, and its verdict in the result queue before the result ports show it.
// Verdicts wait in a small result queue, so characters keep flowing while an
// earlier verdict has not yet been popped; only when that queue is full does a
// last character wait in the token queue, and full rises once the token queue
// fills behind it. The verdict is 0 for neither, 1 for a valid IPv4 address
// and 2 for a valid IPv6 address. Every string must hold at least one character.
// ----------------------------------------------------------------------------
module ip_address_text_validator_top #(
    parameter int QUEUE_DEPTH  = 2,
    parameter int RESULT_DEPTH = 2
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_char_code,
    input  logic       i_is_last,
    output logic       empty,
    input  logic       pop,
    output logic [1:0] o_verdict
);
    import ipval_pkg::*;

    `include "ip_address_text_validator_top_macros.svh"

    localparam int TOKEN_W = $bits(t_token);

    t_token   w_in_token;
    t_token   w_q_token;
    logic [TOKEN_W-1:0] w_q_data;
    logic     w_tok_empty;
    logic     w_tok_pop;
    logic     w_res_full;
    logic     w_res_push;
    t_verdict w_verdict;

    // Front end: classify the character as the item is accepted.
    ipval_front u_front (
        .i_char_code (i_char_code),
        .i_is_last   (i_is_last),
        .o_token     (w_in_token)
    );

    // Token queue between classification and checking.
    ipval_fifo #(
        .WIDTH (TOKEN_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_token_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (w_in_token),
        .o_full  (full),
        .i_pop   (w_tok_pop),
        .o_data  (w_q_data),
        .o_empty (w_tok_empty)
    );

    assign w_q_token = t_token'(w_q_data);

    // A token is taken whenever one waits, except that a last character holds
    // back until the result queue has room for its verdict.
    assign w_tok_pop  = !w_tok_empty && (!w_q_token.last || !w_res_full);
    assign w_res_push = w_tok_pop && w_q_token.last;

    ipval_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_token   (w_q_token),
        .i_take    (w_tok_pop),
        .o_verdict (w_verdict)
    );

    // Result queue towards the consumer.
    ipval_fifo #(
        .WIDTH (2),
        .DEPTH (RESULT_DEPTH)
    ) u_result_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_data  (w_verdict),
        .o_full  (w_res_full),
        .i_pop   (pop),
        .o_data  (o_verdict),
        .o_empty (empty)
    );

    // A verdict is only written while the result queue has room.
    `IPVAL_ASSERT_SAME(a_res_room, i_clk, i_rst_n, w_res_push, !w_res_full)
    // A verdict is written exactly when the last character of a string is checked.
    `IPVAL_ASSERT_SAME(a_res_only_last, i_clk, i_rst_n, w_res_push, w_tok_pop && w_q_token.last)
    // An accepted character is waiting for the checker in the next cycle.
    `IPVAL_ASSERT_NEXT(a_tok_lands, i_clk, i_rst_n, push && !full, !w_tok_empty)
    // A waiting verdict never carries the unused code.
    `IPVAL_ASSERT_SAME(a_verdict_code, i_clk, i_rst_n, !empty, o_verdict != 2'd3)

endmodule

/* rtl/core/ipval_fifo.sv */
// ----------------------------------------------------------------------------
// IP address text validator queue
// Small register queue with full and empty flags; depth is a power of two.
// ----------------------------------------------------------------------------
module ipval_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_do_push;
    logic             w_do_pop;

    assign o_full    = (r_count == CNT_W'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;
    assign o_data    = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (w_do_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            if (w_do_push && !w_do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (w_do_pop && !w_do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

/* rtl/core/ipval_front.sv */
// ----------------------------------------------------------------------------
// IP address text validator front end
// Classifies each incoming character into a token for the checking logic.
// ----------------------------------------------------------------------------
module ipval_front (
    input  logic [7:0]      i_char_code,
    input  logic            i_is_last,
    output ipval_pkg::t_token o_token
);
    import ipval_pkg::*;

    always_comb begin
        o_token.digit = i_char_code[3:0];
        o_token.last  = i_is_last;
        case (i_char_code) inside
            CH_DOT:                      o_token.cls = CLS_DOT;
            CH_COLON:                    o_token.cls = CLS_COLON;
            [8'h30:8'h39]:               o_token.cls = CLS_DIGIT;
            [8'h41:8'h46], [8'h61:8'h66]: o_token.cls = CLS_HEX;
            default:                     o_token.cls = CLS_OTHER;
        endcase
    end

endmodule

/* rtl/core/ipval_back.sv */
// ----------------------------------------------------------------------------
// IP address text validator back end
// Tracks delimiters and the open group, and gives a verdict on the last item.
// ----------------------------------------------------------------------------
module ipval_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ipval_pkg::t_token i_token,
    input  logic              i_take,
    output ipval_pkg::t_verdict o_verdict
);
    import ipval_pkg::*;

    logic [2:0]  r_dot_count;
    logic [3:0]  r_colon_count;
    logic [2:0]  r_group_length;
    logic [9:0]  r_group_value;
    logic        r_group_leading_zero;
    logic        r_v4_possible;
    logic        r_v6_possible;

    logic [2:0]  n_dot_count;
    logic [3:0]  n_colon_count;
    logic [2:0]  n_group_length;
    logic [9:0]  n_group_value;
    logic        n_group_leading_zero;
    logic        n_v4_possible;
    logic        n_v6_possible;

    logic [13:0] w_scaled;
    logic [2:0]  w_len_inc;
    logic        w_v4_ok_cur;
    logic        w_v6_ok_cur;
    logic        w_v4_ok_next;
    logic        w_v6_ok_next;

    // Group checks, on the open group before and after this character.
    assign w_v4_ok_cur = (r_group_length != 3'd0) && (r_group_length <= V4_MAX_LEN)
                      && !(r_group_leading_zero && (r_group_length > 3'd1))
                      && (r_group_value <= V4_MAX_VALUE);
    assign w_v6_ok_cur = (r_group_length != 3'd0) && (r_group_length <= V6_MAX_LEN);

    assign w_v4_ok_next = (n_group_length != 3'd0) && (n_group_length <= V4_MAX_LEN)
                       && !(n_group_leading_zero && (n_group_length > 3'd1))
                       && (n_group_value <= V4_MAX_VALUE);
    assign w_v6_ok_next = (n_group_length != 3'd0) && (n_group_length <= V6_MAX_LEN);

    assign w_len_inc = (r_group_length == 3'd7) ? r_group_length : r_group_length + 3'd1;
    assign w_scaled  = ({4'd0, r_group_value} << 3) + ({4'd0, r_group_value} << 1)
                     + {10'd0, i_token.digit};

    always_comb begin
        n_dot_count          = r_dot_count;
        n_colon_count        = r_colon_count;
        n_group_length       = r_group_length;
        n_group_value        = r_group_value;
        n_group_leading_zero = r_group_leading_zero;
        n_v4_possible        = r_v4_possible;
        n_v6_possible        = r_v6_possible;
        case (i_token.cls)
            CLS_DOT: begin
                n_v4_possible        = r_v4_possible && w_v4_ok_cur;
                n_v6_possible        = 1'b0;
                n_dot_count          = (r_dot_count == 3'd7) ? r_dot_count
                                                             : r_dot_count + 3'd1;
                n_group_length       = '0;
                n_group_value        = '0;
                n_group_leading_zero = 1'b0;
            end
            CLS_COLON: begin
                n_v6_possible        = r_v6_possible && w_v6_ok_cur;
                n_v4_possible        = 1'b0;
                n_colon_count        = (r_colon_count == 4'd15) ? r_colon_count
                                                                : r_colon_count + 4'd1;
                n_group_length       = '0;
                n_group_value        = '0;
                n_group_leading_zero = 1'b0;
            end
            CLS_DIGIT: begin
                if ((r_group_length == 3'd0) && (i_token.digit == 4'd0)) begin
                    n_group_leading_zero = 1'b1;
                end
                n_group_length = w_len_inc;
                n_group_value  = (w_scaled > 14'd1023) ? 10'd1023 : w_scaled[9:0];
            end
            CLS_HEX: begin
                n_v4_possible  = 1'b0;
                n_group_length = w_len_inc;
            end
            default: begin
                n_v4_possible  = 1'b0;
                n_v6_possible  = 1'b0;
                n_group_length = w_len_inc;
            end
        endcase
    end

    always_comb begin
        if ((n_dot_count == V4_DOTS) && n_v4_possible && w_v4_ok_next) begin
            o_verdict = VERDICT_IPV4;
        end else if ((n_colon_count == V6_COLONS) && n_v6_possible && w_v6_ok_next) begin
            o_verdict = VERDICT_IPV6;
        end else begin
            o_verdict = VERDICT_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_take && i_token.last)) begin
            r_dot_count          <= '0;
            r_colon_count        <= '0;
            r_group_length       <= '0;
            r_group_value        <= '0;
            r_group_leading_zero <= 1'b0;
            r_v4_possible        <= 1'b1;
            r_v6_possible        <= 1'b1;
        end else if (i_take) begin
            r_dot_count          <= n_dot_count;
            r_colon_count        <= n_colon_count;
            r_group_length       <= n_group_length;
            r_group_value        <= n_group_value;
            r_group_leading_zero <= n_group_leading_zero;
            r_v4_possible        <= n_v4_possible;
            r_v6_possible        <= n_v6_possible;
        end
    end

endmodule

/* dv/ip_address_text_validator_top_tb.sv */
// ----------------------------------------------------------------------------
// Testbench for the IP address text validator
// Feeds address strings one character item at a time, predicts the verdict of
// each string and checks every verdict item that the block gives back.
// ----------------------------------------------------------------------------
module ip_address_text_validator_top_tb;

    import ipval_pkg::*;

    // Character codes that the classifier cares about, beside the delimiters.
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_F = 8'h66;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_F = 8'h46;

    // Random characters queued after the directed strings.
    localparam int RANDOM_CHARS = 1550;
    // Cycles in which no item moves on either side before the run is declared hung.
    localparam int STALL_LIMIT  = 2000;
    // A verdict passes through both queues of the block after its last character
    // is accepted; allow a generous margin for stray verdicts after the final one.
    localparam int DRAIN_CYCLES = 8;

    // Ways in which a generated address may be spoilt.
    typedef enum int {
        FLAW_NONE,
        FLAW_LEAD_ZERO,
        FLAW_BIG_VALUE,
        FLAW_LONG_GROUP,
        FLAW_HEX_LETTER,
        FLAW_EMPTY_GROUP,
        FLAW_STRAY_CHAR,
        FLAW_EXTRA_GROUP,
        FLAW_MISSING_GROUP,
        FLAW_WRONG_DELIM,
        FLAW_REPLACE
    } t_flaw;

    // One character item waiting to be sent. A set hold bit makes the
    // sender wait until every outstanding verdict has been popped.
    typedef struct packed {
        logic       hold;
        logic       last;
        logic [7:0] code;
    } t_text_char;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       push        = 1'b0;
    logic       full;
    logic [7:0] i_char_code = 8'h00;
    logic       i_is_last   = 1'b0;
    logic       empty;
    logic       pop         = 1'b0;
    logic [1:0] o_verdict;

    ip_address_text_validator_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_char_code (i_char_code),
        .i_is_last   (i_is_last),
        .empty       (empty),
        .pop         (pop),
        .o_verdict   (o_verdict)
    );

    always #10 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Predictor state: a private copy of the counters and flags of the block.
    // ------------------------------------------------------------------------
    logic [2:0] dot_count;
    logic [3:0] colon_count;
    logic [2:0] group_len;
    logic [9:0] group_val;
    logic       group_lead_zero;
    logic       v4_alive;
    logic       v6_alive;

    t_text_char pending_chars[$];
    t_verdict   expected_verdicts[$];
    logic [7:0] draft_text[$];

    t_text_char next_char;
    t_verdict   wanted_verdict;
    int         send_gap   = 0;
    int         send_calm  = 0;
    int         take_stall = 0;
    int         take_calm  = 0;
    int         idle_count = 0;
    int         mismatch_count = 0;

    // Appends to the tail of each of the three queues.
    task automatic append_draft(input logic [7:0] c);
        draft_text = {draft_text, c};
    endtask

    task automatic append_expected(input t_verdict v);
        expected_verdicts = {expected_verdicts, v};
    endtask

    task automatic append_pending(input t_text_char item);
        pending_chars = {pending_chars, item};
    endtask

    task automatic clear_group();
        group_len       = 3'd0;
        group_val       = 10'd0;
        group_lead_zero = 1'b0;
    endtask

    task automatic reset_address_state();
        dot_count   = 3'd0;
        colon_count = 4'd0;
        clear_group();
        v4_alive    = 1'b1;
        v6_alive    = 1'b1;
    endtask

    // A decimal group must hold one to three digits, must not start with a
    // zero unless it is a lone zero, and must not exceed 255.
    function automatic bit v4_group_valid();
        if (group_len == 3'd0 || group_len > V4_MAX_LEN)
            return 1'b0;
        if (group_lead_zero && group_len > 3'd1)
            return 1'b0;
        return group_val <= V4_MAX_VALUE;
    endfunction

    function automatic bit v6_group_valid();
        return group_len != 3'd0 && group_len <= V6_MAX_LEN;
    endfunction

    // Advances the predicted state by one accepted character and, on the
    // last character of a string, queues the verdict it should produce.
    task automatic predict_char(input logic [7:0] c, input logic last);
        int grown;
        if (c == CH_DOT) begin
            if (!v4_group_valid())
                v4_alive = 1'b0;
            v6_alive = 1'b0;
            if (dot_count != 3'd7)
                dot_count = dot_count + 3'd1;
            clear_group();
        end else if (c == CH_COLON) begin
            if (!v6_group_valid())
                v6_alive = 1'b0;
            v4_alive = 1'b0;
            if (colon_count != 4'd15)
                colon_count = colon_count + 4'd1;
            clear_group();
        end else if (c >= CH_ZERO && c <= CH_NINE) begin
            if (group_len == 3'd0 && c == CH_ZERO)
                group_lead_zero = 1'b1;
            if (group_len != 3'd7)
                group_len = group_len + 3'd1;
            // The group value saturates rather than wrapping.
            grown = int'(group_val) * 10 + int'(c - CH_ZERO);
            group_val = (grown > 1023) ? 10'd1023 : grown[9:0];
        end else if ((c >= CH_LOWER_A && c <= CH_LOWER_F) ||
                     (c >= CH_UPPER_A && c <= CH_UPPER_F)) begin
            // A hex letter is fine for IPv6 but rules out IPv4.
            v4_alive = 1'b0;
            if (group_len != 3'd7)
                group_len = group_len + 3'd1;
        end else begin
            // Any other byte, high bytes included, rules out both forms.
            v4_alive = 1'b0;
            v6_alive = 1'b0;
            if (group_len != 3'd7)
                group_len = group_len + 3'd1;
        end
        if (last) begin
            if (dot_count == V4_DOTS && v4_alive && v4_group_valid())
                append_expected(VERDICT_IPV4);
            else if (colon_count == V6_COLONS && v6_alive && v6_group_valid())
                append_expected(VERDICT_IPV6);
            else
                append_expected(VERDICT_NONE);
            reset_address_state();
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus helpers: strings are assembled in draft_text and then queued.
    // ------------------------------------------------------------------------
    function automatic logic [7:0] random_hex_letter();
        return ($urandom_range(0, 1) ? CH_UPPER_A : CH_LOWER_A) + 8'($urandom_range(0, 5));
    endfunction

    function automatic logic [7:0] random_hex_digit();
        if ($urandom_range(0, 15) < 10)
            return CH_ZERO + 8'($urandom_range(0, 9));
        return random_hex_letter();
    endfunction

    // Mostly characters that matter to an address, with some raw bytes.
    function automatic logic [7:0] random_text_char();
        int r;
        r = $urandom_range(0, 9);
        if (r < 3)
            return CH_ZERO + 8'($urandom_range(0, 9));
        else if (r == 3)
            return random_hex_letter();
        else if (r == 4)
            return CH_DOT;
        else if (r == 5)
            return CH_COLON;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic put_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            append_draft(s[i]);
    endtask

    task automatic put_decimal(input int v);
        put_text($sformatf("%0d", v));
    endtask

    // A well-formed group: a decimal value for IPv4, one to four hex digits
    // in mixed case for IPv6. The extremes 0 and 255 are favoured.
    task automatic put_group(input bit v6);
        int r;
        if (v6) begin
            repeat ($urandom_range(1, 4)) append_draft(random_hex_digit());
        end else begin
            r = $urandom_range(0, 9);
            if (r == 0)
                put_decimal(0);
            else if (r == 1)
                put_decimal(255);
            else
                put_decimal($urandom_range(0, 255));
        end
    endtask

    // Builds an address of either form, spoilt in one way when asked.
    task automatic build_address(input bit v6, input bit flawed);
        int         groups;
        int         bad;
        int         g;
        int         p;
        t_flaw      flaw;
        logic [7:0] sep;
        groups = v6 ? 8 : 4;
        sep    = v6 ? CH_COLON : CH_DOT;
        bad    = $urandom_range(0, groups - 1);
        flaw   = flawed ? t_flaw'($urandom_range(FLAW_LEAD_ZERO, FLAW_REPLACE)) : FLAW_NONE;
        if (flaw == FLAW_MISSING_GROUP)
            groups--;
        for (g = 0; g < groups; g++) begin
            if (flaw == FLAW_WRONG_DELIM && g == bad)
                append_draft(v6 ? CH_DOT : CH_COLON);
            else if (g > 0)
                append_draft(sep);
            if (g != bad) begin
                put_group(v6);
            end else begin
                case (flaw)
                    FLAW_LEAD_ZERO: begin
                        append_draft(CH_ZERO);
                        put_decimal($urandom_range(0, 99));
                    end
                    FLAW_BIG_VALUE: put_decimal($urandom_range(256, 9999));
                    FLAW_LONG_GROUP: begin
                        repeat ($urandom_range(4, 9))
                            append_draft(v6 ? random_hex_digit()
                                            : CH_ZERO + 8'($urandom_range(0, 9)));
                    end
                    FLAW_HEX_LETTER: begin
                        put_decimal($urandom_range(0, 99));
                        append_draft(random_hex_letter());
                    end
                    FLAW_EMPTY_GROUP: ;
                    FLAW_STRAY_CHAR: begin
                        put_group(v6);
                        append_draft(8'($urandom_range(0, 255)));
                    end
                    default: put_group(v6);
                endcase
            end
        end
        if (flaw == FLAW_EXTRA_GROUP) begin
            append_draft(sep);
            put_group(v6);
        end
        if (flaw == FLAW_REPLACE && draft_text.size() != 0) begin
            p = $urandom_range(0, draft_text.size() - 1);
            draft_text[p] = random_text_char();
        end
    endtask

    // Moves the draft into the send queue, marking its final character.
    // Every string must hold at least one character.
    task automatic commit_draft(input bit hold);
        int i;
        t_text_char item;
        if (draft_text.size() == 0)
            append_draft(random_text_char());
        for (i = 0; i < draft_text.size(); i++) begin
            item.code = draft_text[i];
            item.last = (i == draft_text.size() - 1);
            item.hold = hold && (i == 0);
            append_pending(item);
        end
        draft_text.delete();
    endtask

    // Idle lengths: mostly none or short, now and then long, and once in a
    // while a calm stretch in which nothing idles at all.
    task automatic pick_idle(inout int calm, output int gap);
        int r;
        if (calm > 0) begin
            calm--;
            gap = 0;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 2) begin
                calm = $urandom_range(20, 60);
                gap  = 0;
            end else if (r < 55) begin
                gap = 0;
            end else if (r < 85) begin
                gap = $urandom_range(1, 3);
            end else if (r < 97) begin
                gap = $urandom_range(4, 12);
            end else begin
                gap = $urandom_range(20, 80);
            end
        end
    endtask

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("[%0t] verdict check: %s", $realtime, what);
    endtask

    // ------------------------------------------------------------------------
    // Driver: offers queued characters, predicting each one as it is taken.
    // A character is only replaced once the current one has been accepted,
    // so push and the payload hold steady while full is high.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full)
                predict_char(i_char_code, i_is_last);
            if (!push || !full) begin
                if (send_gap > 0) begin
                    send_gap--;
                    push <= 1'b0;
                end else if (pending_chars.size() != 0 &&
                             !(pending_chars[0].hold && expected_verdicts.size() != 0)) begin
                    next_char = pending_chars.pop_front();
                    i_char_code <= next_char.code;
                    i_is_last   <= next_char.last;
                    push        <= 1'b1;
                    pick_idle(send_calm, send_gap);
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: pops verdicts with random stalls and checks each one against
    // the oldest prediction. Pop may be high while the block is empty.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (expected_verdicts.size() == 0) begin
                    report_mismatch($sformatf("verdict %0d with none expected", o_verdict));
                end else begin
                    wanted_verdict = expected_verdicts.pop_front();
                    if (o_verdict !== wanted_verdict)
                        report_mismatch($sformatf("got verdict %0d, expected %0d",
                                                  o_verdict, wanted_verdict));
                end
                pick_idle(take_calm, take_stall);
            end
            if (take_stall > 0) begin
                take_stall--;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: the run is hung if no item moves on either side for too long.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((push && !full) || (pop && !empty))
                idle_count = 0;
            else
                idle_count++;
            if (idle_count >= STALL_LIMIT) begin
                $display("ip_address_text_validator_top verification failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run.
    // ------------------------------------------------------------------------
    initial begin
        int pick;
        bit first;
        reset_address_state();

        // Directed strings: a valid IPv4 address with the group extremes, a
        // valid IPv6 address using every hex letter class, a lone delimiter
        // that leaves empty groups, and the lowest and highest byte codes.
        put_text("0.9.1.255");
        commit_draft(1'b0);
        put_text("A:f:0:9:F:a:1:2");
        commit_draft(1'b0);
        put_text(".");
        commit_draft(1'b0);
        append_draft(8'hFF);
        commit_draft(1'b0);
        append_draft(8'h00);
        commit_draft(1'b0);

        // Random strings: mostly well-formed addresses with random content,
        // along with spoilt addresses and plain noise. The first random string and
        // an occasional later one wait for all verdicts to drain first.
        first = 1'b1;
        while (pending_chars.size() < RANDOM_CHARS + 25) begin
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                build_address(1'b0, 1'b0);
            end else if (pick < 65) begin
                build_address(1'b1, 1'b0);
            end else if (pick < 85) begin
                build_address($urandom_range(0, 1), 1'b1);
            end else begin
                repeat ($urandom_range(1, 12)) append_draft(random_text_char());
            end
            commit_draft(first || ($urandom_range(0, 39) == 0));
            first = 1'b0;
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_chars.size() != 0 || push)
            @(posedge i_clk);
        while (expected_verdicts.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("ip_address_text_validator_top verification clean");
        else
            $display("ip_address_text_validator_top verification failed");
        $finish;
    end

endmodule
